// ===== hw/rtl/hwfk_pkg.sv =====
// hwfk_pkg: types, code constants and the halfwidth kana table used by the
// halfwidth to fullwidth kana converter. No dependencies.
`default_nettype none

package hwfk_pkg;

  // code unit constants
  localparam logic [15:0] HW_BASE     = 16'hff60;
  localparam logic [15:0] HW_MASK     = 16'hffe0;
  localparam logic [15:0] HW_BASE_HI  = 16'hff80;
  localparam logic [15:0] VOICED_MARK = 16'hff9e;
  localparam logic [15:0] SEMI_MARK   = 16'hff9f;
  localparam logic [15:0] KA_FIRST    = 16'hff76;
  localparam logic [15:0] TO_LAST     = 16'hff84;
  localparam logic [15:0] HA_FIRST    = 16'hff8a;
  localparam logic [15:0] HO_LAST     = 16'hff8e;

  // one result unit
  typedef struct packed {
    logic [15:0] code;
    logic        last;
  } hwfk_entry_t;

  // results caused by one input transfer, packed from r0
  typedef struct packed {
    logic [1:0]  num;
    hwfk_entry_t r0;
    hwfk_entry_t r1;
  } hwfk_res_t;

  // fixed halfwidth to fullwidth table, indexed by (unit - 0xff60) mod 64
  function automatic logic [15:0] kana_lookup(input logic [5:0] idx);
    logic [15:0] v;
    unique case (idx)
      6'd0:  v = 16'hff60;  6'd1:  v = 16'h3002;  6'd2:  v = 16'h300c;
      6'd3:  v = 16'h300d;  6'd4:  v = 16'h3001;  6'd5:  v = 16'h30fb;
      6'd6:  v = 16'h30f2;  6'd7:  v = 16'h30a1;  6'd8:  v = 16'h30a3;
      6'd9:  v = 16'h30a5;  6'd10: v = 16'h30a7;  6'd11: v = 16'h30a9;
      6'd12: v = 16'h30e3;  6'd13: v = 16'h30e5;  6'd14: v = 16'h30e7;
      6'd15: v = 16'h30c3;  6'd16: v = 16'h30fc;  6'd17: v = 16'h30a2;
      6'd18: v = 16'h30a4;  6'd19: v = 16'h30a6;  6'd20: v = 16'h30a8;
      6'd21: v = 16'h30aa;  6'd22: v = 16'h30ab;  6'd23: v = 16'h30ad;
      6'd24: v = 16'h30af;  6'd25: v = 16'h30b1;  6'd26: v = 16'h30b3;
      6'd27: v = 16'h30b5;  6'd28: v = 16'h30b7;  6'd29: v = 16'h30b9;
      6'd30: v = 16'h30bb;  6'd31: v = 16'h30bd;  6'd32: v = 16'h30bf;
      6'd33: v = 16'h30c1;  6'd34: v = 16'h30c4;  6'd35: v = 16'h30c6;
      6'd36: v = 16'h30c8;  6'd37: v = 16'h30ca;  6'd38: v = 16'h30cb;
      6'd39: v = 16'h30cc;  6'd40: v = 16'h30cd;  6'd41: v = 16'h30ce;
      6'd42: v = 16'h30cf;  6'd43: v = 16'h30d2;  6'd44: v = 16'h30d5;
      6'd45: v = 16'h30d8;  6'd46: v = 16'h30db;  6'd47: v = 16'h30de;
      6'd48: v = 16'h30df;  6'd49: v = 16'h30e0;  6'd50: v = 16'h30e1;
      6'd51: v = 16'h30e2;  6'd52: v = 16'h30e4;  6'd53: v = 16'h30e6;
      6'd54: v = 16'h30e8;  6'd55: v = 16'h30e9;  6'd56: v = 16'h30ea;
      6'd57: v = 16'h30eb;  6'd58: v = 16'h30ec;  6'd59: v = 16'h30ed;
      6'd60: v = 16'h30ef;  6'd61: v = 16'h30f3;  6'd62: v = 16'h309b;
      default: v = 16'h309c;
    endcase
    return v;
  endfunction

  // map one unit: halfwidth block goes through the table, all else passes
  function automatic logic [15:0] convert_unit(input logic [15:0] u);
    logic [15:0] d;
    logic        hw;
    d  = u - HW_BASE;
    hw = ((u & HW_MASK) == HW_BASE) || ((u & HW_MASK) == HW_BASE_HI);
    return hw ? kana_lookup(d[5:0]) : u;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/halfwidth_to_fullwidth_kana.sv =====
// halfwidth_to_fullwidth_kana: top level of the halfwidth to fullwidth kana
// converter; holds the lookahead unit, uses hwfk_conv, hwfk_outq, hwfk_pkg.
//
//   channel | ports                               | direction
//   input   | in_valid in_stall in_code_unit      | in  (in_stall out)
//           | in_end_of_text                      |
//   result  | out_valid out_stall out_code        | out (out_stall in)
//           | out_last                            |
//
// one input transfer per cycle unless in_stall; its results enter the queue
// at that edge and the first can leave on the next cycle, one result per
// cycle after that unless out_stall. a transfer may cause two results (held
// unit plus end of text), so the rate is set by the single output port of
// the three-slot result queue. in_stall rises while two or more results wait
// in the queue. synchronous reset empties the queue and drops any held unit.
`default_nettype none

module halfwidth_to_fullwidth_kana import hwfk_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_code_unit,
  input  wire logic        in_end_of_text,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_code,
  output logic             out_last
);

  logic        held_valid_r;
  logic        held_valid_nxt;
  logic [15:0] held_unit_r;
  logic [15:0] held_unit_nxt;
  logic        space;
  logic        in_xfer;
  hwfk_res_t   res;

  assign in_stall = !space;
  assign in_xfer  = in_valid && !in_stall;

  // conversion against the held unit
  hwfk_conv u_conv (
    .held_valid     (held_valid_r),
    .held_unit      (held_unit_r),
    .code_unit      (in_code_unit),
    .end_of_text    (in_end_of_text),
    .res            (res),
    .held_valid_nxt (held_valid_nxt),
    .held_unit_nxt  (held_unit_nxt)
  );

  // result queue
  hwfk_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_xfer),
    .res       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_code  (out_code),
    .out_last  (out_last)
  );

  // lookahead state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      held_unit_r  <= '0;
    end else if (in_xfer) begin
      held_valid_r <= held_valid_nxt;
      held_unit_r  <= held_unit_nxt;
    end
  end

  a_eot_clears_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_end_of_text |=> !held_valid_r)
    else $error("unit still held after end of text");

  // with nothing held, a unit that is not the last one becomes the lookahead
  a_unit_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !in_end_of_text && !held_valid_r |=>
      held_valid_r && held_unit_r == $past(in_code_unit))
    else $error("accepted unit not held as lookahead");

  a_result_on_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && held_valid_r |=> out_valid)
    else $error("held unit released without a result");

endmodule

`default_nettype wire

// ===== hw/rtl/hwfk_conv.sv =====
// hwfk_conv: one-pass conversion of the incoming unit against the held unit.
// Produces up to two results and the next lookahead state. Uses hwfk_pkg.
`default_nettype none

module hwfk_conv import hwfk_pkg::*; (
  input  wire logic        held_valid,
  input  wire logic [15:0] held_unit,
  input  wire logic [15:0] code_unit,
  input  wire logic        end_of_text,
  output hwfk_res_t        res,
  output logic             held_valid_nxt,
  output logic [15:0]      held_unit_nxt
);

  logic        takes_voiced;
  logic        takes_semi;
  logic        merge_voiced;
  logic        merge_semi;
  logic [15:0] held_conv;
  logic [15:0] cur_conv;
  logic [15:0] merged;

  // merge candidates for the held unit
  assign takes_semi   = (held_unit >= HA_FIRST) && (held_unit <= HO_LAST);
  assign takes_voiced = ((held_unit >= KA_FIRST) && (held_unit <= TO_LAST)) || takes_semi;
  assign merge_voiced = held_valid && (code_unit == VOICED_MARK) && takes_voiced;
  assign merge_semi   = held_valid && (code_unit == SEMI_MARK) && takes_semi;

  assign held_conv = convert_unit(held_unit);
  assign cur_conv  = convert_unit(code_unit);
  assign merged    = held_conv + (merge_semi ? 16'd2 : 16'd1);

  // result list and next held state
  always_comb begin
    res            = '0;
    held_valid_nxt = 1'b0;
    held_unit_nxt  = '0;
    if (merge_voiced || merge_semi) begin
      res.num     = 2'd1;
      res.r0.code = merged;
      res.r0.last = end_of_text;
    end else if (held_valid) begin
      res.r0.code = held_conv;
      res.r0.last = 1'b0;
      if (end_of_text) begin
        res.num     = 2'd2;
        res.r1.code = cur_conv;
        res.r1.last = 1'b1;
      end else begin
        res.num        = 2'd1;
        held_valid_nxt = 1'b1;
        held_unit_nxt  = code_unit;
      end
    end else if (end_of_text) begin
      res.num     = 2'd1;
      res.r0.code = cur_conv;
      res.r0.last = 1'b1;
    end else begin
      held_valid_nxt = 1'b1;
      held_unit_nxt  = code_unit;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hwfk_outq.sv =====
// hwfk_outq: three-slot shifting result queue that takes up to two results
// per transfer and delivers one per transfer. Uses hwfk_pkg.
`default_nettype none

module hwfk_outq import hwfk_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  hwfk_res_t        res,
  output logic             space,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_code,
  output logic             out_last
);

  localparam int Slots = 3;

  hwfk_entry_t slot_r   [Slots];
  hwfk_entry_t slot_nxt [Slots];
  logic [1:0]  count_r;
  logic [1:0]  count_nxt;
  logic [1:0]  base;
  logic        pop;

  assign pop       = out_valid && !out_stall;
  assign space     = (count_r <= 2'd1);
  assign out_valid = (count_r != 2'd0);
  assign out_code  = slot_r[0].code;
  assign out_last  = slot_r[0].last;
  assign base      = count_r - {1'b0, pop};

  // shift on pop, then place new results behind what remains
  always_comb begin
    for (int i = 0; i < Slots; i++) begin
      slot_nxt[i] = slot_r[i];
      if (pop && (i < Slots - 1)) begin
        slot_nxt[i] = slot_r[i + 1];
      end
      if (push && (res.num != 2'd0) && (2'(i) == base)) begin
        slot_nxt[i] = res.r0;
      end
      if (push && (res.num == 2'd2) && (2'(i) == base + 2'd1)) begin
        slot_nxt[i] = res.r1;
      end
    end
    count_nxt = base + (push ? res.num : 2'd0);
  end

  // occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // slot payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < Slots; i++) begin
      slot_r[i] <= slot_nxt[i];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd0 || !out_valid)
    else $error("queue shows a result while empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> count_r <= 2'd1)
    else $error("push into queue without room for two results");

  a_keep_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped from queue");

endmodule

`default_nettype wire

// ===== dv/tb_halfwidth_to_fullwidth_kana.sv =====
// tb_halfwidth_to_fullwidth_kana: self-checking bench for the halfwidth to
// fullwidth kana converter, with a directed table, random texts and a predictor.
// depends on hwfk_pkg (constants, result entry type) and halfwidth_to_fullwidth_kana.
`default_nettype none

module tb_halfwidth_to_fullwidth_kana;
  import hwfk_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASE_UNITS = 380;

  // directed row: expected single result typed in where it is obvious
  typedef struct packed {
    logic [15:0] unit;
    logic        eot;
    logic        typed;
    logic [15:0] want;
  } stim_row_t;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [15:0] in_code_unit   = 16'h0000;
  logic        in_end_of_text = 1'b0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic [15:0] out_code;
  logic        out_last;

  // side info travelling with the offered unit
  logic        row_typed = 1'b0;
  logic [15:0] row_want  = 16'h0000;

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_req     = 0;
  int hold_done    = 0;
  int hold_left    = 0;
  int cycle_cnt    = 0;
  int err_cnt      = 0;
  int sent_cnt     = 0;
  int in_xfer_cnt  = 0;
  int res_cnt      = 0;
  int merge_cnt    = 0;
  int in_block_cnt = 0;

  // predictor state: the lookahead unit
  logic [15:0] kana_held     = 16'h0000;
  logic        kana_held_vld = 1'b0;

  hwfk_entry_t pending_kana[$];

  // fullwidth forms of 0xff60..0xff9f
  logic [15:0] fw_table [0:63] = '{
    16'hff60, 16'h3002, 16'h300c, 16'h300d, 16'h3001, 16'h30fb, 16'h30f2, 16'h30a1,
    16'h30a3, 16'h30a5, 16'h30a7, 16'h30a9, 16'h30e3, 16'h30e5, 16'h30e7, 16'h30c3,
    16'h30fc, 16'h30a2, 16'h30a4, 16'h30a6, 16'h30a8, 16'h30aa, 16'h30ab, 16'h30ad,
    16'h30af, 16'h30b1, 16'h30b3, 16'h30b5, 16'h30b7, 16'h30b9, 16'h30bb, 16'h30bd,
    16'h30bf, 16'h30c1, 16'h30c4, 16'h30c6, 16'h30c8, 16'h30ca, 16'h30cb, 16'h30cc,
    16'h30cd, 16'h30ce, 16'h30cf, 16'h30d2, 16'h30d5, 16'h30d8, 16'h30db, 16'h30de,
    16'h30df, 16'h30e0, 16'h30e1, 16'h30e2, 16'h30e4, 16'h30e6, 16'h30e8, 16'h30e9,
    16'h30ea, 16'h30eb, 16'h30ec, 16'h30ed, 16'h30ef, 16'h30f3, 16'h309b, 16'h309c
  };

  // extremes, marks alone, merges mid-text and on the last unit, near misses
  stim_row_t dir_rows [0:24] = '{
    '{16'h0000, 1'b1, 1'b1, 16'h0000},
    '{16'hffff, 1'b1, 1'b1, 16'hffff},
    '{16'hff60, 1'b1, 1'b1, 16'hff60},
    '{VOICED_MARK, 1'b1, 1'b1, 16'h309b},
    '{SEMI_MARK, 1'b1, 1'b1, 16'h309c},
    '{KA_FIRST, 1'b0, 1'b0, 16'h0000},
    '{VOICED_MARK, 1'b0, 1'b1, 16'h30ac},
    '{HA_FIRST, 1'b0, 1'b0, 16'h0000},
    '{SEMI_MARK, 1'b1, 1'b1, 16'h30d1},
    '{TO_LAST, 1'b0, 1'b0, 16'h0000},
    '{SEMI_MARK, 1'b0, 1'b1, 16'h30c8},
    '{HO_LAST, 1'b0, 1'b1, 16'h309c},
    '{VOICED_MARK, 1'b1, 1'b1, 16'h30dc},
    '{16'hff85, 1'b0, 1'b0, 16'h0000},
    '{VOICED_MARK, 1'b1, 1'b0, 16'h0000},
    '{16'hff75, 1'b0, 1'b0, 16'h0000},
    '{VOICED_MARK, 1'b0, 1'b1, 16'h30aa},
    '{VOICED_MARK, 1'b0, 1'b1, 16'h309b},
    '{16'hff89, 1'b0, 1'b1, 16'h309b},
    '{SEMI_MARK, 1'b0, 1'b1, 16'h30ce},
    '{16'hff8f, 1'b1, 1'b0, 16'h0000},
    '{16'hff5f, 1'b0, 1'b0, 16'h0000},
    '{16'hffa0, 1'b0, 1'b1, 16'hff5f},
    '{16'hffe0, 1'b1, 1'b0, 16'h0000},
    '{16'hff80, 1'b1, 1'b1, 16'h30bf}
  };

  halfwidth_to_fullwidth_kana dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_code_unit   (in_code_unit),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code       (out_code),
    .out_last       (out_last)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // halfwidth block goes through the table, everything else is untouched
  function automatic logic [15:0] to_fullwidth(input logic [15:0] u);
    logic [15:0] off;
    off = u - 16'hff60;
    if (u >= 16'hff60 && u <= 16'hff9f) return fw_table[off[5:0]];
    return u;
  endfunction

  // advance the lookahead state by one unit and list the results it frees
  function automatic void kana_convert_step(input logic [15:0] c, input logic eot,
                                            output int n, output hwfk_entry_t r0,
                                            output hwfk_entry_t r1);
    logic [15:0] h;
    logic [1:0]  add;
    logic        ha_ho;
    logic        ka_to;
    hwfk_entry_t e;
    n     = 0;
    r0    = '0;
    r1    = '0;
    h     = kana_held;
    ha_ho = (h >= HA_FIRST && h <= HO_LAST);
    ka_to = (h >= KA_FIRST && h <= TO_LAST);
    if (kana_held_vld) begin
      add = 2'd0;
      if (c == VOICED_MARK && (ka_to || ha_ho)) add = 2'd1;
      else if (c == SEMI_MARK && ha_ho) add = 2'd2;
      if (add != 2'd0) begin
        // mark is swallowed by the held kana
        r0            = '{code: to_fullwidth(h) + 16'(add), last: eot};
        n             = 1;
        kana_held_vld = 1'b0;
        kana_held     = 16'h0000;
        merge_cnt++;
        return;
      end
      r0 = '{code: to_fullwidth(h), last: 1'b0};
      n  = 1;
    end
    if (eot) begin
      e = '{code: to_fullwidth(c), last: 1'b1};
      if (n == 0) r0 = e;
      else r1 = e;
      n++;
      kana_held_vld = 1'b0;
      kana_held     = 16'h0000;
    end else begin
      kana_held     = c;
      kana_held_vld = 1'b1;
    end
  endfunction

  // predict on input transfers, check on result transfers
  always @(posedge clk) begin
    int          n;
    hwfk_entry_t r0;
    hwfk_entry_t r1;
    hwfk_entry_t want;
    if (rst_n) begin
      if (in_valid && in_stall) in_block_cnt++;
      if (in_valid && !in_stall) begin
        in_xfer_cnt++;
        kana_convert_step(in_code_unit, in_end_of_text, n, r0, r1);
        if (row_typed) begin
          pending_kana.push_back('{code: row_want, last: in_end_of_text});
        end else begin
          if (n > 0) pending_kana.push_back(r0);
          if (n > 1) pending_kana.push_back(r1);
        end
      end
      if (out_valid && !out_stall) begin
        res_cnt++;
        if (pending_kana.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result code=%h last=%b", $time, out_code, out_last);
        end else begin
          want = pending_kana.pop_front();
          if (out_code !== want.code) begin
            err_cnt++;
            $display("%0t: code mismatch: expected %h, got %h", $time, want.code, out_code);
          end
          if (out_last !== want.last) begin
            err_cnt++;
            $display("%0t: last mismatch: expected %b, got %b", $time, want.last, out_last);
          end
        end
      end
    end
  end

  // receiver: random stall, or a long hold-off when asked
  always @(negedge clk) begin
    if (hold_done != hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_done = hold_req;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: run limit reached with %0d results pending", $time,
               pending_kana.size());
      $display("tb_halfwidth_to_fullwidth_kana: errors");
      $finish;
    end
  end

  // offer one unit and wait for its transfer
  task automatic offer_unit(input logic [15:0] unit, input logic eot,
                            input logic typed, input logic [15:0] want);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_code_unit   = unit;
    in_end_of_text = eot;
    row_typed      = typed;
    row_want       = want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_cnt++;
  endtask

  // one random text: kana pairs with marks, bare halfwidth, marks, noise
  task automatic offer_text();
    int          len;
    int          i;
    int          pick;
    logic [15:0] u;
    logic [15:0] mark;
    len = $urandom_range(1, 10);
    i   = 0;
    while (i < len) begin
      pick = $urandom_range(99);
      if (pick < 30 && i + 1 < len) begin
        // voiceable kana or a neighbor, then a mark
        if ($urandom_range(1)) u = 16'($urandom_range(16'hff75, 16'hff85));
        else u = 16'($urandom_range(16'hff89, 16'hff8f));
        mark = $urandom_range(1) ? VOICED_MARK : SEMI_MARK;
        offer_unit(u, 1'b0, 1'b0, 16'h0000);
        offer_unit(mark, (i + 2 == len), 1'b0, 16'h0000);
        i += 2;
      end else begin
        if (pick < 55) u = 16'hff60 + 16'($urandom_range(63));
        else if (pick < 65) u = $urandom_range(1) ? VOICED_MARK : SEMI_MARK;
        else u = 16'($urandom);
        offer_unit(u, (i + 1 == len), 1'b0, 16'h0000);
        i++;
      end
    end
  endtask

  // sender pause until every expected result has come
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_kana.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    snd_idle_pct = 23;
    rcv_idle_pct = 61;
    for (int k = 0; k < 25; k++) begin
      offer_unit(dir_rows[k].unit, dir_rows[k].eot, dir_rows[k].typed, dir_rows[k].want);
    end
    wait_drained();

    // random texts, sender idles less than receiver
    sent_cnt = 0;
    while (sent_cnt < PHASE_UNITS) offer_text();
    wait_drained();

    // receiver idles less than sender
    snd_idle_pct = 61;
    rcv_idle_pct = 23;
    sent_cnt     = 0;
    while (sent_cnt < PHASE_UNITS) offer_text();
    wait_drained();

    // no idling; long receiver hold-off fills the block
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_req++;
    sent_cnt = 0;
    while (sent_cnt < PHASE_UNITS) offer_text();
    wait_drained();
    repeat (16) @(posedge clk);

    $display("%0d units sent, %0d results checked, %0d kana+mark merges",
             in_xfer_cnt, res_cnt, merge_cnt);
    $display("%0d cycles with input held off, three idle profiles plus a %0d-cycle hold",
             in_block_cnt, HOLD_CYCLES);
    if (err_cnt == 0) begin
      $display("tb_halfwidth_to_fullwidth_kana: clean");
    end else begin
      $display("tb_halfwidth_to_fullwidth_kana: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
